// File: sv/assert_macros.svh
// Assertion macros used by the RTL file bss_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/bss_pkg.sv
package bss_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int PTR_W       = IDX_W + 2;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = ((IDX_W + 2 * DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((1 + IDX_W + 7) / 8) * 8;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [PTR_W-1:0]  ptr_t;
  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic we;
    idx_t addr;
    word_t wdata;
  } ram_req_t;

endpackage

// File: sv/bss_ram.sv
module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/bss_ctrl.sv
`include "assert_macros.svh"

module bss_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bss_pkg::cnt_t                  count,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_cmd,
  input  bss_pkg::idx_t                  in_index,
  input  bss_pkg::word_t                 in_value,
  input  bss_pkg::word_t                 in_key,
  output bss_pkg::ram_req_t              ram_req,
  input  logic [bss_pkg::DATA_W-1:0]     ram_rdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_found,
  output bss_pkg::idx_t                  out_position
);
  import bss_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  logic [1:0] state_r, state_nxt;
  ptr_t       lo_r, lo_nxt, hi_r, hi_nxt;
  idx_t       mid_r, mid_nxt;
  word_t      key_r, key_nxt;
  logic       found_r, found_nxt;
  idx_t       pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_found_r, out_found_nxt;
  idx_t       out_pos_r, out_pos_nxt;

  logic       accept;
  ptr_t       hi_init;
  ptr_t       mid_ext;
  ptr_t       lo_step, hi_step, sum;
  word_t      probe;
  logic       out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign hi_init   = $signed({1'b0, count}) - ptr_t'(1);
  assign mid_ext   = $signed({2'b00, mid_r});
  assign probe     = $signed(ram_rdata);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    lo_step       = lo_r;
    hi_step       = hi_r;
    sum           = '0;
    ram_req.we    = 1'b0;
    ram_req.addr  = mid_r;
    ram_req.wdata = in_value;

    unique case (state_r)
      ST_IDLE: begin
        ram_req.addr = in_index;
        if (accept) begin
          if (in_cmd == CMD_WRITE) begin
            ram_req.we = 1'b1;
          end else begin
            key_nxt      = in_key;
            lo_nxt       = '0;
            hi_nxt       = hi_init;
            mid_nxt      = hi_init[IDX_W:1];
            ram_req.addr = hi_init[IDX_W:1];
            found_nxt    = 1'b0;
            pos_nxt      = '0;
            // empty table: answer at once
            state_nxt    = (count == '0) ? ST_DONE : ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (probe == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r;
          state_nxt = ST_DONE;
        end else begin
          if (probe < key_r) begin
            lo_step = mid_ext + ptr_t'(1);
          end else begin
            hi_step = mid_ext - ptr_t'(1);
          end
          lo_nxt = lo_step;
          hi_nxt = hi_step;
          sum    = lo_step + hi_step;
          if (lo_step > hi_step) begin
            state_nxt = ST_DONE;
          end else begin
            mid_nxt      = sum[IDX_W:1];
            ram_req.addr = sum[IDX_W:1];
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_pos_nxt   = found_r ? pos_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

  `ASSERT_IMPL(a_write_only_idle, clk, rst_n, ram_req.we, state_r == ST_IDLE,
               "table write outside idle")
  `ASSERT_IMPL(a_mid_in_window, clk, rst_n, state_r == ST_SEARCH,
               (lo_r <= mid_ext) && (mid_ext <= hi_r), "probe outside search window")
  `ASSERT_IMPL(a_miss_pos_zero, clk, rst_n, out_valid_r && !out_found_r,
               out_pos_r == '0, "miss reports nonzero position")
  `ASSERT_NEXT(a_done_loads, clk, rst_n, (state_r == ST_DONE) && out_free,
               out_valid_r && (state_r == ST_IDLE), "finished search not delivered")

endmodule

// File: sv/binary_search_sorted_table_top.sv
// Channel | Direction | Handshake           | Payload
// in      | slave     | in_tvalid/in_tready | tuser: command; tdata: index, value, key
// out     | master    | out_tvalid/out_tready | tdata: found, position
// cfg     | slave     | cfg_valid/cfg_ready | cfg_data: entry_count
//
// A write request updates the table RAM when it is accepted. A search makes
// at most log2(count) + 1 probes; the single-port table RAM gives one probe
// per cycle.
// Reset clears the entry count and control state; table contents are undefined.
// A result waits in the output register; a search that finishes while it is
// full holds until it frees, and no new request is taken meanwhile.
module binary_search_sorted_table_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bss_pkg::IN_TDATA_W-1:0]   in_tdata,  // entry_index, entry_value, search_key, pad
  input  logic [0:0]                       in_tuser,  // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bss_pkg::OUT_TDATA_W-1:0]  out_tdata, // found, position, pad
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  bss_pkg::cnt_t                    cfg_data
);
  import bss_pkg::*;

  cnt_t     count_r, count_nxt;
  cnt_t     count_sat;
  ram_req_t ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic     found;
  idx_t     position;

  assign cfg_ready = 1'b1;
  assign count_nxt = (cfg_valid && cfg_ready) ? cfg_data : count_r;
  assign count_sat = (count_r > cnt_t'(TABLE_DEPTH)) ? cnt_t'(TABLE_DEPTH) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  bss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .addr (ram_req.addr),
    .wdata(ram_req.wdata),
    .rdata(ram_rdata)
  );

  bss_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .count       (count_sat),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_cmd      (in_tuser[0]),
    .in_index    (in_tdata[IDX_W-1:0]),
    .in_value    (in_tdata[IDX_W+DATA_W-1:IDX_W]),
    .in_key      (in_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W]),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_found   (found),
    .out_position(position)
  );

  assign out_tdata = {{(OUT_TDATA_W-1-IDX_W){1'b0}}, position, found};

endmodule
